FILE: design/infix_expression_evaluator_unit_macros.svh
// Assertion macros for the infix expression evaluator.
// Used by the top level only.
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IEU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define IEU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ieu_pkg.sv
// Shared types, constants and functions of the infix expression evaluator.
// No dependencies.
`timescale 1ns / 1ps

package ieu_pkg;

    localparam int DATA_W             = 32;
    localparam int CHAR_W             = 8;
    localparam int VARIABLE_SLOTS_DEF = 16;
    localparam int STACK_DEPTH_DEF    = 32;
    // token queue depth, power of two
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_A      = 8'h61;
    localparam logic [CHAR_W-1:0] CH_Z      = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_P      = 8'h70;
    localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
    localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h74;

    typedef enum logic [2:0] {
        OPK_PAREN = 3'd0,
        OPK_ADD   = 3'd1,
        OPK_SUB   = 3'd2,
        OPK_MUL   = 3'd3,
        OPK_DIV   = 3'd4
    } opk_t;

    typedef enum logic [2:0] {
        CLS_DIGIT  = 3'd0,
        CLS_SPACE  = 3'd1,
        CLS_LPAREN = 3'd2,
        CLS_RPAREN = 3'd3,
        CLS_OPER   = 3'd4,
        CLS_LETTER = 3'd5,
        CLS_OTHER  = 3'd6
    } tok_class_t;

    // one classified character
    typedef struct packed {
        logic [CHAR_W-1:0] chr;
        logic              eol;
        tok_class_t        cls;
        opk_t              opk;
    } tok_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic idle;
        logic div_busy;
    } back_stat_t;

    function automatic logic [1:0] rank_of(opk_t k);
        logic [1:0] r;
        case (k)
            OPK_PAREN: r = 2'd0;
            OPK_ADD:   r = 2'd1;
            OPK_SUB:   r = 2'd1;
            default:   r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

FILE: design/ieu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ieu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/ieu_front.sv
// Front end: accepts characters, classifies them and queues the tokens.
// Depends on ieu_pkg.
`timescale 1ns / 1ps

module ieu_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] character
    input  logic                           s_tlast,
    output logic                           tok_valid,
    output ieu_pkg::tok_t                  tok,
    input  logic                           tok_pop
);

    localparam int QAW = $clog2(ieu_pkg::QUEUE_DEPTH);
    localparam int QCW = $clog2(ieu_pkg::QUEUE_DEPTH + 1);

    ieu_pkg::tok_t  queue [ieu_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] wptr_reg, wptr_next;
    logic [QAW-1:0] rptr_reg, rptr_next;
    logic [QCW-1:0] count_reg, count_next;
    ieu_pkg::tok_t  in_tok;
    logic           push;

    // classify the incoming character
    always_comb
    begin
        in_tok.chr = s_tdata;
        in_tok.eol = s_tlast;
        in_tok.opk = ieu_pkg::OPK_ADD;
        if (s_tdata >= ieu_pkg::CH_0 && s_tdata <= ieu_pkg::CH_9)
        begin
            in_tok.cls = ieu_pkg::CLS_DIGIT;
        end
        else if (s_tdata >= ieu_pkg::CH_A && s_tdata <= ieu_pkg::CH_Z)
        begin
            in_tok.cls = ieu_pkg::CLS_LETTER;
        end
        else if (s_tdata == ieu_pkg::CH_SPACE)
        begin
            in_tok.cls = ieu_pkg::CLS_SPACE;
        end
        else if (s_tdata == ieu_pkg::CH_LPAREN)
        begin
            in_tok.cls = ieu_pkg::CLS_LPAREN;
        end
        else if (s_tdata == ieu_pkg::CH_RPAREN)
        begin
            in_tok.cls = ieu_pkg::CLS_RPAREN;
        end
        else if (s_tdata == ieu_pkg::CH_PLUS)
        begin
            in_tok.cls = ieu_pkg::CLS_OPER;
        end
        else if (s_tdata == ieu_pkg::CH_MINUS)
        begin
            in_tok.cls = ieu_pkg::CLS_OPER;
            in_tok.opk = ieu_pkg::OPK_SUB;
        end
        else if (s_tdata == ieu_pkg::CH_STAR)
        begin
            in_tok.cls = ieu_pkg::CLS_OPER;
            in_tok.opk = ieu_pkg::OPK_MUL;
        end
        else if (s_tdata == ieu_pkg::CH_SLASH)
        begin
            in_tok.cls = ieu_pkg::CLS_OPER;
            in_tok.opk = ieu_pkg::OPK_DIV;
        end
        else
        begin
            in_tok.cls = ieu_pkg::CLS_OTHER;
        end
    end

    assign s_tready  = (count_reg != QCW'(ieu_pkg::QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign tok_valid = (count_reg != '0);
    assign tok       = queue[rptr_reg];

    // queue pointers
    always_comb
    begin
        wptr_next  = push ? wptr_reg + QAW'(1) : wptr_reg;
        rptr_next  = tok_pop ? rptr_reg + QAW'(1) : rptr_reg;
        count_next = count_reg + QCW'(push) - QCW'(tok_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue[wptr_reg] <= in_tok;
        end
    end

endmodule

FILE: design/ieu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating.
// Depends on ieu_pkg.
`timescale 1ns / 1ps

module ieu_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ieu_pkg::DATA_W-1:0] dividend,
    input  logic [ieu_pkg::DATA_W-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [ieu_pkg::DATA_W-1:0] quotient
);

    localparam int W  = ieu_pkg::DATA_W;
    localparam int NW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W-1:0]  mb_reg, mb_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    assign shifted = {rem_reg, dvd_reg[W-1]};
    assign diff    = shifted - {1'b0, mb_reg};

    // restoring step, quotient bits shift into the dividend register
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        mb_next   = mb_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            dvd_next  = dividend[W-1] ? W'(-dividend) : dividend;
            mb_next   = divisor[W-1] ? W'(-divisor) : divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                dvd_next = {dvd_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                dvd_next = {dvd_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + NW'(1);
            if (cnt_reg == NW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        mb_reg  <= mb_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? W'(-dvd_reg) : dvd_reg;

endmodule

FILE: design/ieu_back.sv
// Back end: statement parser, operator and value stacks, variable table.
// Depends on ieu_pkg, ieu_ram and ieu_div.
`timescale 1ns / 1ps

module ieu_back #(
    parameter int VARIABLE_SLOTS = ieu_pkg::VARIABLE_SLOTS_DEF,
    parameter int STACK_DEPTH    = ieu_pkg::STACK_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tok_valid,
    input  ieu_pkg::tok_t              tok,
    output logic                       tok_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // [31:0] value
    output logic                       m_tuser,   // [0] status
    output ieu_pkg::back_stat_t        stat
);

    localparam int W  = ieu_pkg::DATA_W;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SW = $clog2(VARIABLE_SLOTS);

    // line position codes
    localparam logic [2:0] POS_START = 3'd0;
    localparam logic [2:0] POS_EQ_R  = 3'd1;
    localparam logic [2:0] POS_I     = 3'd2;
    localparam logic [2:0] POS_N     = 3'd3;
    localparam logic [2:0] POS_T     = 3'd4;
    localparam logic [2:0] POS_EXPR  = 3'd5;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_CHAR   = 10'b0000000100,
        S_LOOP   = 10'b0000001000,
        S_AP1    = 10'b0000010000,
        S_DIV    = 10'b0000100000,
        S_RELOAD = 10'b0001000000,
        S_FIN    = 10'b0010000000,
        S_FIN2   = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        CTX_RPAREN = 2'd0,
        CTX_OPER   = 2'd1,
        CTX_FIN    = 2'd2
    } ctx_t;

    state_t            state_reg, state_next;
    ctx_t              ctx_reg, ctx_next;
    logic [7:0]        chr_reg, chr_next;
    logic              eol_reg, eol_next;
    ieu_pkg::tok_class_t cls_reg, cls_next;
    ieu_pkg::opk_t     topk_reg, topk_next;
    ieu_pkg::opk_t     kop_reg, kop_next;

    logic [2:0]        pos_reg, pos_next;
    logic              kind_reg, kind_next;
    logic [7:0]        target_reg, target_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic              inlit_reg, inlit_next;
    logic [CW-1:0]     parens_reg, parens_next;
    logic              skip_reg, skip_next;

    logic [CW-1:0]     otop_reg, otop_next;
    ieu_pkg::opk_t     opt_reg, opt_next;
    logic [CW-1:0]     vtop_reg, vtop_next;
    logic [W-1:0]      vtv_reg, vtv_next;

    logic              res_err_reg, res_err_next;
    logic [W-1:0]      res_val_reg, res_val_next;
    logic              out_valid_reg, out_valid_next;
    logic [W-1:0]      out_value_reg, out_value_next;
    logic              out_status_reg, out_status_next;

    logic [7:0]        var_names [VARIABLE_SLOTS];
    logic [W-1:0]      var_values [VARIABLE_SLOTS];
    logic [VARIABLE_SLOTS-1:0] var_valid_reg, var_valid_next;
    logic              tab_we;
    logic [SW-1:0]     tab_idx;

    logic              vwe, owe;
    logic [AW-1:0]     vwaddr, vraddr, owaddr, oraddr;
    logic [W-1:0]      vwdata, vrdata;
    logic [2:0]        owdata, ordata;

    logic              vpush_req, opush_req, err, clr;
    logic [W-1:0]      vpush_data;
    ieu_pkg::opk_t     opush_kind;

    logic [CW-1:0]     vm1, vm2, om1, om2;
    logic [W-1:0]      opa, opb;
    logic              loop_cond;

    logic [7:0]        key;
    logic              match_found, free_found;
    logic [SW-1:0]     match_idx, free_idx;

    logic              div_start, div_busy, div_done;
    logic [W-1:0]      div_q;

    assign vm1 = vtop_reg - CW'(1);
    assign vm2 = vtop_reg - CW'(2);
    assign om1 = otop_reg - CW'(1);
    assign om2 = otop_reg - CW'(2);

    ieu_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_vram (
        .clk   (clk),
        .we    (vwe),
        .waddr (vwaddr),
        .wdata (vwdata),
        .raddr (vraddr),
        .rdata (vrdata)
    );

    ieu_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_oram (
        .clk   (clk),
        .we    (owe),
        .waddr (owaddr),
        .wdata (owdata),
        .raddr (oraddr),
        .rdata (ordata)
    );

    ieu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (opa),
        .divisor  (opb),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // variable table search: name match and lowest free slot
    assign key = (state_reg == S_FIN2) ? target_reg : chr_reg;

    always_comb
    begin
        match_found = 1'b0;
        match_idx   = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        for (int i = VARIABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (var_valid_reg[i] && var_names[i] == key)
            begin
                match_found = 1'b1;
                match_idx   = SW'(i);
            end
            if (!var_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    // operands of the applied operator
    assign opa = (vtop_reg > CW'(1)) ? vrdata : '0;
    assign opb = vtv_reg;

    // pop condition of the current reduction loop
    always_comb
    begin
        case (ctx_reg)
            CTX_RPAREN: loop_cond = (opt_reg != ieu_pkg::OPK_PAREN);
            CTX_OPER:   loop_cond = (ieu_pkg::rank_of(opt_reg) >= ieu_pkg::rank_of(kop_reg));
            default:    loop_cond = 1'b1;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ctx_next        = ctx_reg;
        chr_next        = chr_reg;
        eol_next        = eol_reg;
        cls_next        = cls_reg;
        topk_next       = topk_reg;
        kop_next        = kop_reg;
        pos_next        = pos_reg;
        kind_next       = kind_reg;
        target_next     = target_reg;
        acc_next        = acc_reg;
        inlit_next      = inlit_reg;
        parens_next     = parens_reg;
        skip_next       = skip_reg;
        otop_next       = otop_reg;
        opt_next        = opt_reg;
        vtop_next       = vtop_reg;
        vtv_next        = vtv_reg;
        res_err_next    = res_err_reg;
        res_val_next    = res_val_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        var_valid_next  = var_valid_reg;
        tab_we          = 1'b0;
        tab_idx         = match_idx;
        tok_pop         = 1'b0;
        vwe             = 1'b0;
        vwaddr          = vm1[AW-1:0];
        vwdata          = vtv_reg;
        vraddr          = vm2[AW-1:0];
        owe             = 1'b0;
        owaddr          = om1[AW-1:0];
        owdata          = opt_reg;
        oraddr          = om2[AW-1:0];
        vpush_req       = 1'b0;
        vpush_data      = acc_reg;
        opush_req       = 1'b0;
        opush_kind      = kop_reg;
        err             = 1'b0;
        clr             = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (tok_valid)
                begin
                    tok_pop    = 1'b1;
                    chr_next   = tok.chr;
                    eol_next   = tok.eol;
                    cls_next   = tok.cls;
                    topk_next  = tok.opk;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = eol_reg ? S_FIN : S_IDLE;
                if (skip_reg)
                begin
                    clr        = eol_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    case (pos_reg)
                        POS_START:
                        begin
                            if (cls_reg == ieu_pkg::CLS_LETTER)
                            begin
                                target_next = chr_reg;
                                pos_next    = POS_EQ_R;
                            end
                            else
                            begin
                                err = 1'b1;
                            end
                        end
                        POS_EQ_R:
                        begin
                            if (chr_reg == ieu_pkg::CH_EQUAL)
                            begin
                                kind_next = 1'b1;
                                pos_next  = POS_EXPR;
                            end
                            else if (target_reg == ieu_pkg::CH_P && chr_reg == ieu_pkg::CH_R)
                            begin
                                pos_next = POS_I;
                            end
                            else
                            begin
                                err = 1'b1;
                            end
                        end
                        POS_I:
                        begin
                            if (chr_reg == ieu_pkg::CH_I) pos_next = POS_N;
                            else err = 1'b1;
                        end
                        POS_N:
                        begin
                            if (chr_reg == ieu_pkg::CH_N) pos_next = POS_T;
                            else err = 1'b1;
                        end
                        POS_T:
                        begin
                            if (chr_reg == ieu_pkg::CH_T)
                            begin
                                kind_next = 1'b0;
                                pos_next  = POS_EXPR;
                            end
                            else
                            begin
                                err = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (cls_reg == ieu_pkg::CLS_DIGIT)
                            begin
                                // acc * 10 + digit, wrapping
                                acc_next   = (inlit_reg ? ((acc_reg << 3) + (acc_reg << 1)) : '0)
                                             + W'(chr_reg - ieu_pkg::CH_0);
                                inlit_next = 1'b1;
                            end
                            else
                            begin
                                // a non-digit ends the literal
                                vpush_req  = inlit_reg;
                                inlit_next = 1'b0;
                                state_next = S_CHAR;
                            end
                        end
                    endcase
                end
            end

            S_CHAR:
            begin
                state_next = eol_reg ? S_FIN : S_IDLE;
                case (cls_reg)
                    ieu_pkg::CLS_SPACE:
                    begin
                    end
                    ieu_pkg::CLS_LPAREN:
                    begin
                        opush_req   = 1'b1;
                        opush_kind  = ieu_pkg::OPK_PAREN;
                        parens_next = parens_reg + CW'(1);
                    end
                    ieu_pkg::CLS_RPAREN:
                    begin
                        if (parens_reg == '0)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            ctx_next   = CTX_RPAREN;
                            state_next = S_LOOP;
                        end
                    end
                    ieu_pkg::CLS_OPER:
                    begin
                        kop_next   = topk_reg;
                        ctx_next   = CTX_OPER;
                        state_next = S_LOOP;
                    end
                    ieu_pkg::CLS_LETTER:
                    begin
                        if (match_found)
                        begin
                            vpush_req  = 1'b1;
                            vpush_data = var_values[match_idx];
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    default:
                    begin
                        err = 1'b1;
                    end
                endcase
            end

            S_LOOP:
            begin
                if (otop_reg != '0 && loop_cond)
                begin
                    // fetch next-to-top value and operator below the top
                    if (vtop_reg == '0) err = 1'b1;
                    else state_next = S_AP1;
                end
                else
                begin
                    case (ctx_reg)
                        CTX_RPAREN:
                        begin
                            if (otop_reg == '0)
                            begin
                                err = 1'b1;
                            end
                            else
                            begin
                                otop_next   = om1;
                                parens_next = parens_reg - CW'(1);
                                state_next  = S_RELOAD;
                            end
                        end
                        CTX_OPER:
                        begin
                            opush_req  = 1'b1;
                            state_next = eol_reg ? S_FIN : S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_FIN2;
                        end
                    endcase
                end
            end

            S_AP1:
            begin
                otop_next  = om1;
                opt_next   = ieu_pkg::opk_t'(ordata);
                state_next = S_LOOP;
                if (vtop_reg > CW'(1)) vtop_next = vm1;
                case (opt_reg)
                    ieu_pkg::OPK_ADD: vtv_next = opa + opb;
                    ieu_pkg::OPK_SUB: vtv_next = opa - opb;
                    ieu_pkg::OPK_MUL: vtv_next = W'(opa * opb);
                    ieu_pkg::OPK_DIV:
                    begin
                        if (opb == '0)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default: err = 1'b1;
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    vtv_next   = div_q;
                    state_next = S_LOOP;
                end
            end

            S_RELOAD:
            begin
                opt_next   = ieu_pkg::opk_t'(ordata);
                state_next = eol_reg ? S_FIN : S_IDLE;
            end

            S_FIN:
            begin
                if (pos_reg != POS_EXPR || parens_reg != '0)
                begin
                    err = 1'b1;
                end
                else
                begin
                    vpush_req  = inlit_reg;
                    inlit_next = 1'b0;
                    ctx_next   = CTX_FIN;
                    state_next = S_LOOP;
                end
            end

            S_FIN2:
            begin
                if (vtop_reg == '0)
                begin
                    err = 1'b1;
                end
                else if (!kind_reg)
                begin
                    res_err_next = 1'b0;
                    res_val_next = vtv_reg;
                    state_next   = S_EMIT;
                end
                else if (match_found || free_found)
                begin
                    tab_we                  = 1'b1;
                    tab_idx                 = match_found ? match_idx : free_idx;
                    var_valid_next[tab_idx] = 1'b1;
                    clr                     = 1'b1;
                    state_next              = S_IDLE;
                end
                else
                begin
                    err = 1'b1;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_err_reg ? '0 : res_val_reg;
                    out_status_next = res_err_reg;
                    clr             = eol_reg;
                    skip_next       = !eol_reg && res_err_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // shared value push, top held in a register
        if (vpush_req)
        begin
            if (vtop_reg == CW'(STACK_DEPTH))
            begin
                err = 1'b1;
            end
            else
            begin
                vwe       = (vtop_reg != '0);
                vtv_next  = vpush_data;
                vtop_next = vtop_reg + CW'(1);
            end
        end

        // shared operator push, top held in a register
        if (opush_req)
        begin
            if (otop_reg == CW'(STACK_DEPTH))
            begin
                err = 1'b1;
            end
            else
            begin
                owe       = (otop_reg != '0);
                opt_next  = opush_kind;
                otop_next = otop_reg + CW'(1);
            end
        end

        // error transaction
        if (err)
        begin
            res_err_next = 1'b1;
            res_val_next = '0;
            state_next   = S_EMIT;
        end

        // end of line returns line state to its start values
        if (clr)
        begin
            pos_next    = POS_START;
            kind_next   = 1'b0;
            target_next = '0;
            acc_next    = '0;
            inlit_next  = 1'b0;
            parens_next = '0;
            skip_next   = 1'b0;
            otop_next   = '0;
            vtop_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= POS_START;
            kind_reg      <= 1'b0;
            target_reg    <= '0;
            acc_reg       <= '0;
            inlit_reg     <= 1'b0;
            parens_reg    <= '0;
            skip_reg      <= 1'b0;
            otop_reg      <= '0;
            vtop_reg      <= '0;
            out_valid_reg <= 1'b0;
            var_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            kind_reg      <= kind_next;
            target_reg    <= target_next;
            acc_reg       <= acc_next;
            inlit_reg     <= inlit_next;
            parens_reg    <= parens_next;
            skip_reg      <= skip_next;
            otop_reg      <= otop_next;
            vtop_reg      <= vtop_next;
            out_valid_reg <= out_valid_next;
            var_valid_reg <= var_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ctx_reg        <= ctx_next;
        chr_reg        <= chr_next;
        eol_reg        <= eol_next;
        cls_reg        <= cls_next;
        topk_reg       <= topk_next;
        kop_reg        <= kop_next;
        opt_reg        <= opt_next;
        vtv_reg        <= vtv_next;
        res_err_reg    <= res_err_next;
        res_val_reg    <= res_val_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        if (tab_we)
        begin
            var_names[tab_idx]  <= target_reg;
            var_values[tab_idx] <= vtv_reg;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_value_reg;
    assign m_tuser       = out_status_reg;
    assign stat.idle     = (state_reg == S_IDLE);
    assign stat.div_busy = div_busy;

endmodule

FILE: design/infix_expression_evaluator_unit.sv
// Infix expression evaluator: one character per input transaction.
// Characters are queued in the front end, so input is accepted while the back-end sequencer
// still works on earlier ones, until the token queue is full. Each applied operator adds
// sequencer states, and each division waits on the iterative divider.
// Reset: rst_n asynchronous, clears stacks, line state and table.
`timescale 1ns / 1ps
`include "infix_expression_evaluator_unit_macros.svh"

module infix_expression_evaluator_unit #(
    parameter int VARIABLE_SLOTS = ieu_pkg::VARIABLE_SLOTS_DEF,
    parameter int STACK_DEPTH    = ieu_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic        m_tuser    // [0] status
);

    logic                tok_valid;
    logic                tok_pop;
    ieu_pkg::tok_t       tok;
    ieu_pkg::back_stat_t stat;

    ieu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop)
    );

    ieu_back #(
        .VARIABLE_SLOTS (VARIABLE_SLOTS),
        .STACK_DEPTH    (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .stat      (stat)
    );

    // checks
    `IEU_ASSERT_NOW(a_err_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == 32'd0, "error with value")
    `IEU_ASSERT_NOW(a_pop_valid, clk, rst_n, tok_pop, tok_valid, "pop from empty queue")
    `IEU_ASSERT_NXT(a_pop_busy, clk, rst_n, tok_pop, !stat.idle, "token not taken")
    `IEU_ASSERT_NOW(a_div_busy, clk, rst_n, stat.div_busy, !stat.idle, "divider runs while idle")

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the infix expression evaluator: feeds statement lines,
// predicts print values and error results, and checks every output transaction.
// Depends on ieu_pkg and infix_expression_evaluator_unit.
`timescale 1ns / 1ps

// Holds the expected results and the evaluator state predicted from accepted bytes
class line_result_board;
    localparam int SLOTS = 16;
    localparam int DEPTH = 32;
    localparam int EXPR = 5;

    logic [2:0]  ops[DEPTH];
    int          op_cnt;
    logic [31:0] vals[DEPTH];
    int          val_cnt;
    logic [7:0]  var_name[SLOTS];
    logic [31:0] var_val[SLOTS];
    bit          var_ok[SLOTS];
    int          pos;
    bit          is_assign;
    logic [7:0]  target;
    logic [31:0] lit;
    bit          in_lit;
    int          parens;
    bit          skipping;

    logic [32:0] pending[$];
    int          mismatches;

    function new();
        for (int i = 0; i < SLOTS; i++) var_ok[i] = 0;
        mismatches = 0;
        clear_line();
    endfunction

    function void clear_line();
        op_cnt = 0; val_cnt = 0; pos = 0; is_assign = 0; target = 0;
        lit = 0; in_lit = 0; parens = 0; skipping = 0;
    endfunction

    function int rank(logic [2:0] k);
        if (k == ieu_pkg::OPK_PAREN) return 0;
        if (k == ieu_pkg::OPK_ADD || k == ieu_pkg::OPK_SUB) return 1;
        return 2;
    endfunction

    function bit push_val(logic [31:0] v);
        if (val_cnt >= DEPTH) return 0;
        vals[val_cnt++] = v;
        return 1;
    endfunction

    function bit push_op(logic [2:0] k);
        if (op_cnt >= DEPTH) return 0;
        ops[op_cnt++] = k;
        return 1;
    endfunction

    // pop one operator and apply it; a lone value takes 0 on the left
    function bit reduce();
        logic [2:0]  k;
        logic [31:0] a, b, r;
        a = 0;
        if (op_cnt == 0 || val_cnt == 0) return 0;
        k = ops[--op_cnt];
        b = vals[--val_cnt];
        if (val_cnt > 0) a = vals[--val_cnt];
        case (k)
            ieu_pkg::OPK_ADD: r = a + b;
            ieu_pkg::OPK_SUB: r = a - b;
            ieu_pkg::OPK_MUL: r = a * b;
            ieu_pkg::OPK_DIV:
            begin
                if (b == 0) return 0;
                if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = a;
                else r = $signed(a) / $signed(b);
            end
            default: return 0;
        endcase
        return push_val(r);
    endfunction

    function bit flush_lit();
        if (!in_lit) return 1;
        in_lit = 0;
        return push_val(lit);
    endfunction

    function bit expr_byte(logic [7:0] c);
        logic [2:0] k;
        if (c >= ieu_pkg::CH_0 && c <= ieu_pkg::CH_9) begin
            if (!in_lit) begin in_lit = 1; lit = 0; end
            lit = lit * 10 + (c - ieu_pkg::CH_0);
            return 1;
        end
        if (!flush_lit()) return 0;
        if (c == ieu_pkg::CH_SPACE) return 1;
        if (c == ieu_pkg::CH_LPAREN) begin
            if (!push_op(ieu_pkg::OPK_PAREN)) return 0;
            parens++;
            return 1;
        end
        if (c == ieu_pkg::CH_RPAREN) begin
            if (parens == 0) return 0;
            while (op_cnt > 0 && ops[op_cnt-1] != ieu_pkg::OPK_PAREN)
                if (!reduce()) return 0;
            if (op_cnt == 0) return 0;
            op_cnt--; parens--;
            return 1;
        end
        if (c == ieu_pkg::CH_PLUS || c == ieu_pkg::CH_MINUS ||
            c == ieu_pkg::CH_STAR || c == ieu_pkg::CH_SLASH) begin
            k = (c == ieu_pkg::CH_PLUS) ? ieu_pkg::OPK_ADD :
                (c == ieu_pkg::CH_MINUS) ? ieu_pkg::OPK_SUB :
                (c == ieu_pkg::CH_STAR) ? ieu_pkg::OPK_MUL : ieu_pkg::OPK_DIV;
            while (op_cnt > 0 && rank(ops[op_cnt-1]) >= rank(k))
                if (!reduce()) return 0;
            return push_op(k);
        end
        if (c >= ieu_pkg::CH_A && c <= ieu_pkg::CH_Z) begin
            for (int i = 0; i < SLOTS; i++)
                if (var_ok[i] && var_name[i] == c) return push_val(var_val[i]);
            return 0;
        end
        return 0;
    endfunction

    function bit take_byte(logic [7:0] c);
        case (pos)
            0:
            begin
                if (c < ieu_pkg::CH_A || c > ieu_pkg::CH_Z) return 0;
                target = c; pos = 1; return 1;
            end
            1:
            begin
                if (c == ieu_pkg::CH_EQUAL) begin is_assign = 1; pos = EXPR; return 1; end
                if (target == ieu_pkg::CH_P && c == ieu_pkg::CH_R) begin pos = 2; return 1; end
                return 0;
            end
            2: begin if (c != ieu_pkg::CH_I) return 0; pos = 3; return 1; end
            3: begin if (c != ieu_pkg::CH_N) return 0; pos = 4; return 1; end
            4: begin if (c != ieu_pkg::CH_T) return 0; is_assign = 0; pos = EXPR; return 1; end
            default: return expr_byte(c);
        endcase
    endfunction

    // end of line: evaluate the rest; printed set when a value is due
    function bit end_line(output logic [31:0] v, output bit printed);
        int slot;
        printed = 0; v = 0; slot = SLOTS;
        if (pos != EXPR) return 0;
        if (!flush_lit()) return 0;
        if (parens != 0) return 0;
        while (op_cnt > 0) if (!reduce()) return 0;
        if (val_cnt == 0) return 0;
        v = vals[val_cnt-1];
        if (!is_assign) begin printed = 1; return 1; end
        for (int i = 0; i < SLOTS; i++)
            if (slot == SLOTS && var_ok[i] && var_name[i] == target) slot = i;
        for (int i = 0; i < SLOTS; i++)
            if (slot == SLOTS && !var_ok[i]) slot = i;
        if (slot == SLOTS) return 0;
        var_name[slot] = target; var_val[slot] = v; var_ok[slot] = 1;
        return 1;
    endfunction

    // note one accepted input transaction
    function void note_byte(logic [7:0] c, bit eol);
        bit          bad, printed;
        logic [31:0] v;
        bad = 0; printed = 0; v = 0;
        if (!skipping) begin
            bad = !take_byte(c);
            if (!bad && eol) bad = !end_line(v, printed);
        end
        if (eol) clear_line();
        else if (bad) skipping = 1;
        if (bad) pending.push_back({1'b1, 32'h0});
        else if (printed) pending.push_back({1'b0, v});
    endfunction

    // check one output transaction against the oldest expectation
    function void check_result(logic [31:0] v, logic st);
        logic [32:0] exp_r;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result value=%0d status=%0b", v, st);
            return;
        end
        exp_r = pending.pop_front();
        if (exp_r[32] !== st || exp_r[31:0] !== v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected value=%0d status=%0b, got value=%0d status=%0b",
                         $signed(exp_r[31:0]), exp_r[32], $signed(v), st);
        end
    endfunction
endclass

module testbench;

    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    line_result_board board;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;
    int          byte_count;
    logic [7:0]  line_buf[$];

    infix_expression_evaluator_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 0;
    always #1 clk = ~clk;

    // receiver: random ready, changed on the falling edge
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // output check and watchdog on the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // send one byte, holding it until the transaction completes; valid stays
    // high afterwards so that back-to-back bytes need one assignment per edge
    task automatic send_byte(input logic [7:0] c, input bit eol);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1; s_tdata <= c; s_tlast <= eol;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_byte(c, eol);
        byte_count++;
        @(negedge clk);
    endtask

    // send the buffered line, last byte marked as end of line
    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic line_of(input string s);
        put_text(s);
        send_line();
    endtask

    function automatic logic [7:0] rand_var();
        return 8'(ieu_pkg::CH_A + $urandom_range(7));
    endfunction

    // random well-formed expression with occasional noise
    task automatic put_expr(input int depth);
        int terms;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++) begin
            if (t > 0 || $urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: line_buf.push_back(ieu_pkg::CH_PLUS);
                    1: line_buf.push_back(ieu_pkg::CH_MINUS);
                    2: line_buf.push_back(ieu_pkg::CH_STAR);
                    default: line_buf.push_back(ieu_pkg::CH_SLASH);
                endcase
            end
            if ($urandom_range(4) == 0) line_buf.push_back(ieu_pkg::CH_SPACE);
            case ($urandom_range(5))
                0, 1: put_text($sformatf("%0d", $urandom_range(20)));
                2: put_text($sformatf("%0d", $urandom()));
                3: line_buf.push_back(rand_var());
                default:
                begin
                    if (depth < 3) begin
                        line_buf.push_back(ieu_pkg::CH_LPAREN);
                        put_expr(depth + 1);
                        line_buf.push_back(ieu_pkg::CH_RPAREN);
                    end else put_text($sformatf("%0d", $urandom_range(9)));
                end
            endcase
        end
        if ($urandom_range(40) == 0) line_buf.push_back(8'($urandom()));
        if ($urandom_range(40) == 0) line_buf.push_back(ieu_pkg::CH_RPAREN);
        if ($urandom_range(40) == 0) line_buf.push_back(ieu_pkg::CH_LPAREN);
    endtask

    task automatic random_line();
        case ($urandom_range(19))
            0:
            begin
                // pure noise
                repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom()));
            end
            1, 2, 3, 4, 5, 6:
            begin
                line_buf.push_back(rand_var());
                line_buf.push_back(ieu_pkg::CH_EQUAL);
                put_expr(0);
            end
            7:
            begin
                // far-off names fill the table now and then
                line_buf.push_back(8'(ieu_pkg::CH_A + $urandom_range(25)));
                line_buf.push_back(ieu_pkg::CH_EQUAL);
                put_expr(0);
            end
            default:
            begin
                put_text("print");
                put_expr(0);
            end
        endcase
        send_line();
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        string deep;
        board = new();
        send_idle_pct = 15;
        recv_idle_pct = 68;
        quiet_cycles = 0;
        byte_count = 0;
        rst_n = 0; s_tvalid = 0; s_tdata = 0; s_tlast = 0; m_tready = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: prefixes, operators, precedence, errors
        line_of("print7");
        line_of("a=2147483647");
        line_of("b=0-2147483647-1");
        line_of("print a + 1");
        line_of("print b/-1");
        line_of("print b / (0-1) * 3");
        line_of("print 10-4-3");
        line_of("print -5/2+2*3");
        line_of("print 7/0");
        line_of("print q");
        line_of("print (1+2");
        line_of("print 1+2)");
        line_of("print ()5");
        line_of("print");
        line_of("prin");
        line_of("Print 1");
        line_of("x 1");
        line_of("print 1 2 3");
        line_of("print 4294967301 #9");
        line_of("print *");
        line_of("print 99999999999");
        line_of("a=a*a");
        line_of("print a");
        deep = "print ";
        for (int i = 0; i < 34; i++) deep = {deep, "("};
        line_of(deep);
        deep = "print ";
        for (int i = 0; i < 33; i++) deep = {deep, "1 "};
        line_of(deep);
        send_byte(8'hFF, 1);
        send_byte(8'h00, 1);
        drain();

        // random phases with varying idling
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 68; recv_idle_pct = 15; end
            if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            while (byte_count < 400 * (ph + 1) + 50) random_line();
            drain();
        end

        if (board.mismatches == 0 && board.pending.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

FILE: infix_expression_evaluator_unit.f
+incdir+design
design/ieu_pkg.sv
design/ieu_ram.sv
design/ieu_front.sv
design/ieu_div.sv
design/ieu_back.sv
design/infix_expression_evaluator_unit.sv
bench/testbench.sv
